// File: design/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Holds register codes, configuration and result structs and default sizes.
// No dependencies; every other file of the block uses it by scoped names.
package wbps_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_PATTERN_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	// Pattern bytes that have a register behind them.
	localparam int NUM_CARE = 16;

	// Width of the pattern length register.
	localparam int LEN_CFG_W = 5;

	// Configuration bus: 64-bit registers at byte address 8*i.
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 6;
	localparam int REG_SEL_LSB = 3;
	localparam int REG_SEL_W = 3;

	// Reset value of the pattern length register.
	localparam logic [LEN_CFG_W-1:0] LEN_RESET = LEN_CFG_W'(1);

	// Register indexes on the configuration bus.
	typedef enum logic [REG_SEL_W-1:0] {
		REG_PAT_LO = 3'd0,
		REG_PAT_HI = 3'd1,
		REG_CARE   = 3'd2,
		REG_LEN    = 3'd3,
		REG_OFFSET = 3'd4,
		REG_BASE   = 3'd5
	} reg_idx_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [63:0]          pat_lo;
		logic [63:0]          pat_hi;
		logic [NUM_CARE-1:0]  care_mask;
		logic [LEN_CFG_W-1:0] pattern_length;
		logic [63:0]          addr_bias;      // base address plus signed offset
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic        found;
		logic [63:0] match_address;
		logic        scan_done;
	} result_t;

endpackage

// File: design/wbps_cfg_regs.sv
// Configuration register file of the wildcard byte pattern scanner.
// APB-style write and read port; presents the registers as wbps_pkg::cfg_t.
// Depends on wbps_pkg.
module wbps_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wbps_pkg::PADDR_W-1:0] paddr,
	input  logic [wbps_pkg::PDATA_W-1:0] pwdata,
	output logic [wbps_pkg::PDATA_W-1:0] prdata,
	output wbps_pkg::cfg_t               cfg
);

	logic [63:0]                    pat_lo_q;
	logic [63:0]                    pat_hi_q;
	logic [wbps_pkg::NUM_CARE-1:0]  care_q;
	logic [wbps_pkg::LEN_CFG_W-1:0] len_q;
	logic signed [31:0]             offset_q;
	logic [63:0]                    base_q;
	logic [63:0]                    bias_q;
	logic                           wr_en;
	wbps_pkg::reg_idx_t             sel;

	assign wr_en = psel && penable && pwrite;
	assign sel   = wbps_pkg::reg_idx_t'(
		paddr[wbps_pkg::REG_SEL_LSB +: wbps_pkg::REG_SEL_W]);

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= wbps_pkg::LEN_RESET;
			offset_q <= '0;
			base_q   <= '0;
		end else if (wr_en) begin
			case (sel)
				wbps_pkg::REG_PAT_LO: pat_lo_q <= pwdata[63:0];
				wbps_pkg::REG_PAT_HI: pat_hi_q <= pwdata[63:0];
				wbps_pkg::REG_CARE:   care_q   <= pwdata[wbps_pkg::NUM_CARE-1:0];
				wbps_pkg::REG_LEN:    len_q    <= pwdata[wbps_pkg::LEN_CFG_W-1:0];
				wbps_pkg::REG_OFFSET: offset_q <= signed'(pwdata[31:0]);
				wbps_pkg::REG_BASE:   base_q   <= pwdata[63:0];
				default: ;
			endcase
		end
	end

	// The base and the sign-extended offset are summed ahead of time, so the
	// match path only adds the start index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else begin
			bias_q <= base_q + {{32{offset_q[31]}}, offset_q};
		end
	end

	// Read data.
	always_comb begin
		case (sel)
			wbps_pkg::REG_PAT_LO: prdata = pat_lo_q;
			wbps_pkg::REG_PAT_HI: prdata = pat_hi_q;
			wbps_pkg::REG_CARE:   prdata = {{(64-wbps_pkg::NUM_CARE){1'b0}}, care_q};
			wbps_pkg::REG_LEN:    prdata = {{(64-wbps_pkg::LEN_CFG_W){1'b0}}, len_q};
			wbps_pkg::REG_OFFSET: prdata = {32'd0, offset_q};
			wbps_pkg::REG_BASE:   prdata = base_q;
			default:              prdata = '0;
		endcase
	end

	assign cfg.pat_lo         = pat_lo_q;
	assign cfg.pat_hi         = pat_hi_q;
	assign cfg.care_mask      = care_q;
	assign cfg.pattern_length = len_q;
	assign cfg.addr_bias      = bias_q;

endmodule

// File: design/wbps_match.sv
// Window, byte counter and match logic of the wildcard byte pattern scanner.
// Compares all window positions in parallel and keeps the first match address.
// Depends on wbps_pkg.
module wbps_match #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = wbps_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wbps_pkg::cfg_t    cfg,
	input  logic              item_valid,
	input  logic              advance,
	input  logic [7:0]        data_byte_s1,
	input  logic              last_byte_s1,
	output logic              emit,
	output wbps_pkg::result_t result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [7:0]             window_q [MAX_PATTERN-1];
	logic [7:0]             hist [MAX_PATTERN];
	logic [LEN_W-1:0]       len_q;
	logic [MAX_PATTERN-1:0] want_care_q;
	logic [7:0]             want_byte_q [MAX_PATTERN];
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   found_q;
	logic [63:0]            found_addr_q;
	logic [COUNT_WIDTH-1:0] count_nxt;
	logic [COUNT_WIDTH-1:0] start_idx;
	logic [MAX_PATTERN-1:0] pos_ok;
	logic                   match;
	logic                   first_hit;
	logic [63:0]            hit_addr;
	logic [LEN_W-1:0]       len_c;
	logic [MAX_PATTERN-1:0] care_c;
	logic [7:0]             byte_c [MAX_PATTERN];
	logic [127:0]           pat_all;

	// Clamp the length and align the pattern to window ages; window age a
	// faces pattern byte len-1-a. Registered, so the compare has fixed taps.
	always_comb begin
		int pos;
		pat_all = {cfg.pat_hi, cfg.pat_lo};
		if (cfg.pattern_length == '0) begin
			len_c = LEN_W'(1);
		end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
			len_c = LEN_W'(MAX_PATTERN);
		end else begin
			len_c = LEN_W'(cfg.pattern_length);
		end
		for (int a = 0; a < MAX_PATTERN; a++) begin
			pos = int'(len_c) - 1 - a;
			care_c[a] = 1'b0;
			byte_c[a] = '0;
			if (pos >= 0 && pos < wbps_pkg::NUM_CARE) begin
				care_c[a] = cfg.care_mask[pos[3:0]];
				byte_c[a] = pat_all[{pos[3:0], 3'b000} +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(1);
			want_care_q <= '0;
		end else begin
			len_q       <= len_c;
			want_care_q <= care_c;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < MAX_PATTERN; a++) begin
			want_byte_q[a] <= byte_c[a];
		end
	end

	// Byte history: age 0 is the byte now in the input register.
	always_comb begin
		hist[0] = data_byte_s1;
		for (int a = 1; a < MAX_PATTERN; a++) begin
			hist[a] = window_q[a-1];
		end
	end

	// Parallel compare; a match must lie fully inside this scan.
	always_comb begin
		count_nxt = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);
		for (int a = 0; a < MAX_PATTERN; a++) begin
			pos_ok[a] = !want_care_q[a] || (hist[a] == want_byte_q[a]);
		end
		match     = (count_nxt >= COUNT_WIDTH'(len_q)) && (&pos_ok);
		first_hit = match && !found_q;
		start_idx = count_nxt - COUNT_WIDTH'(len_q);
		hit_addr  = cfg.addr_bias + 64'(start_idx);
	end

	// Result for the item in the input register.
	always_comb begin
		emit                 = item_valid && (first_hit || last_byte_s1);
		result.found         = found_q || first_hit;
		result.scan_done     = last_byte_s1;
		if (first_hit) begin
			result.match_address = hit_addr;
		end else if (found_q) begin
			result.match_address = found_addr_q;
		end else begin
			result.match_address = '0;
		end
	end

	// Scan state; the last byte starts a new scan. Window bytes older than
	// the count are never compared, so the window needs no clearing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (advance) begin
			if (last_byte_s1) begin
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				count_q <= count_nxt;
				found_q <= found_q || match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q[0] <= data_byte_s1;
			for (int k = 1; k < MAX_PATTERN - 1; k++) begin
				window_q[k] <= window_q[k-1];
			end
			if (first_hit) begin
				found_addr_q <= hit_addr;
			end
		end
	end

	// The end of a scan clears the counter and the found flag.
	a_scan_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_byte_s1 |=> count_q == '0 && !found_q)
		else $error("scan state not cleared after last byte");

	// A match needs at least one byte of the scan.
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> count_q != '0)
		else $error("found flag set with empty scan");

	// A result in mid-scan is only ever the first match.
	a_mid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !last_byte_s1 |-> result.found && !found_q)
		else $error("mid-scan result that is not a first match");

endmodule

// File: design/wildcard_byte_pattern_scanner_core.sv
// Top level of the wildcard byte pattern scanner.
// Input register, match stage (wbps_match), result register, config regs.
// Depends on wbps_pkg, wbps_cfg_regs and wbps_match.
//
//   channel | direction | handshake           | beat contents
//   in      | input     | in_valid / in_stall   | data_byte, last_byte
//   out     | output    | out_valid / out_stall | found, match_address, scan_done
//   cfg     | input     | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// One byte per cycle while no held result stalls the input: a byte lands in the
// input register and is compared against the whole window while it sits there;
// any result is loaded into the result register as it leaves the match stage.
// Reset clears the scan state and the registers to their defaults.
// A stalled result holds the match stage only when that stage has a result to
// hand over; bytes that cause no result keep flowing.
module wildcard_byte_pattern_scanner_core #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = wbps_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [63:0]                  match_address,
	output logic                         scan_done,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wbps_pkg::PADDR_W-1:0] paddr,
	input  logic [wbps_pkg::PDATA_W-1:0] pwdata,
	output logic [wbps_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	wbps_pkg::cfg_t    cfg;
	wbps_pkg::result_t res;
	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              last_byte_s1;
	logic              emit;
	logic              out_free;
	logic              advance;
	logic              in_take;
	logic              out_valid_q;
	wbps_pkg::result_t out_q;

	assign pready = 1'b1;

	wbps_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	wbps_match #(
		.MAX_PATTERN(MAX_PATTERN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_valid  (valid_s1),
		.advance     (advance),
		.data_byte_s1(data_byte_s1),
		.last_byte_s1(last_byte_s1),
		.emit        (emit),
		.result      (res)
	);

	// Flow control between the stages.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_q.found;
	assign match_address = out_q.match_address;
	assign scan_done     = out_q.scan_done;

	// Only a held byte can stall the input.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && emit && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// A result leaving the match stage shows up in the result register.
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> out_valid_q)
		else $error("result lost between stages");

	// A byte with no result never waits.
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !emit |-> advance)
		else $error("byte without result held in the input register");

endmodule
